[src/operand_stack_alu_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the operand stack ALU.
// ---------------------------------------------------------------------------
`ifndef OPERAND_STACK_ALU_ASSERT_SVH
`define OPERAND_STACK_ALU_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define OSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define OSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/osa_pkg.sv]
// ---------------------------------------------------------------------------
// osa_pkg
// Shared codes for the operand stack ALU.
// ---------------------------------------------------------------------------
package osa_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_OP    = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_SHIFT   = 3'd4
  } status_e;

  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_SUB    = 5'd1;
  localparam logic [4:0] OP_MUL    = 5'd2;
  localparam logic [4:0] OP_DIV    = 5'd3;
  localparam logic [4:0] OP_MOD    = 5'd4;
  localparam logic [4:0] OP_LOR    = 5'd5;
  localparam logic [4:0] OP_XOR    = 5'd6;
  localparam logic [4:0] OP_LAND   = 5'd7;
  localparam logic [4:0] OP_AND    = 5'd8;
  localparam logic [4:0] OP_OR     = 5'd9;
  localparam logic [4:0] OP_SHL    = 5'd10;
  localparam logic [4:0] OP_SHR    = 5'd11;
  localparam logic [4:0] OP_LT     = 5'd12;
  localparam logic [4:0] OP_GT     = 5'd13;
  localparam logic [4:0] OP_EQ     = 5'd14;
  localparam logic [4:0] OP_NEG    = 5'd15;
  localparam logic [4:0] OP_PLUS   = 5'd16;
  localparam logic [4:0] OP_BITNOT = 5'd17;
  localparam logic [4:0] OP_LOGNOT = 5'd18;

endpackage

[src/operand_stack_alu.sv]
// ---------------------------------------------------------------------------
// operand_stack_alu
// Reverse-Polish ALU on an operand stack held in a synchronous memory.
// ---------------------------------------------------------------------------
// Sequence: push, clear, ignored and underflow transactions go straight from
// acceptance to S_DONE; unary operators pass through S_EXEC, and binary
// operators through S_RD_A (one memory read) and S_EXEC; div and mod then run
// the radix-2 divider in S_DIV and write back in S_DIVWB before S_DONE.
// One transaction is worked on at a time; the next is accepted once the
// result register is free. Reset clears the stack count; memory is not cleared.
module operand_stack_alu #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic signed [31:0] push_value_i,
  input  logic [4:0]  op_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic signed [31:0] top_value_o,
  output logic [4:0]  stack_count_o
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = $clog2(DATA_WIDTH);
  localparam int DCW = $clog2(DATA_WIDTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD_A  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DIVWB = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [DATA_WIDTH-1:0] ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [DATA_WIDTH-1:0] ZERO = '0;

  logic [DATA_WIDTH-1:0] mem_q [STACK_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         sp_q, sp_d;
  logic [DATA_WIDTH-1:0] top_q, top_d;
  logic [DATA_WIDTH-1:0] b_q, b_d;
  logic [4:0]            op_q, op_d;
  logic [2:0]            st_q, st_d;
  logic                  ov_q, ov_d;

  // Divider state.
  logic [DATA_WIDTH-1:0] dq_q, dq_d;
  logic [DATA_WIDTH-1:0] dr_q, dr_d;
  logic [DATA_WIDTH-1:0] dd_q, dd_d;
  logic [DCW-1:0]        dcnt_q, dcnt_d;
  logic                  dsa_q, dsa_d, dsb_q, dsb_d;

  logic                  take;
  logic [DATA_WIDTH-1:0] a_v, res;
  logic [2:0]            ex_st;
  logic [DATA_WIDTH:0]   dtrial, rshift;
  logic [DATA_WIDTH-1:0] dres;

  assign in_stall_o = (state_q != S_IDLE) || ov_q;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Binary/unary execute on a_v (memory read data) and b_q.
  always_comb begin
    a_v   = rd_data_q;
    res   = '0;
    ex_st = osa_pkg::ST_OK;
    case (op_q)
      osa_pkg::OP_ADD:  res = a_v + b_q;
      osa_pkg::OP_SUB:  res = a_v - b_q;
      osa_pkg::OP_MUL:  res = DATA_WIDTH'(a_v * b_q);
      osa_pkg::OP_LOR:  res = ((a_v != ZERO) || (b_q != ZERO)) ? ONE : ZERO;
      osa_pkg::OP_XOR:  res = a_v ^ b_q;
      osa_pkg::OP_LAND: res = ((a_v != ZERO) && (b_q != ZERO)) ? ONE : ZERO;
      osa_pkg::OP_AND:  res = a_v & b_q;
      osa_pkg::OP_OR:   res = a_v | b_q;
      osa_pkg::OP_SHL, osa_pkg::OP_SHR: begin
        if (b_q[DATA_WIDTH-1] || (b_q > DATA_WIDTH'(DATA_WIDTH - 1))) begin
          ex_st = osa_pkg::ST_SHIFT;
        end else if (op_q == osa_pkg::OP_SHL) begin
          res = a_v << b_q[SW-1:0];
        end else begin
          res = DATA_WIDTH'($signed(a_v) >>> b_q[SW-1:0]);
        end
      end
      osa_pkg::OP_LT:   res = ($signed(a_v) < $signed(b_q)) ? ONE : ZERO;
      osa_pkg::OP_GT:   res = ($signed(b_q) < $signed(a_v)) ? ONE : ZERO;
      osa_pkg::OP_EQ:   res = (a_v == b_q) ? ONE : ZERO;
      osa_pkg::OP_NEG:    res = ZERO - b_q;
      osa_pkg::OP_PLUS:   res = b_q;
      osa_pkg::OP_BITNOT: res = ~b_q;
      osa_pkg::OP_LOGNOT: res = (b_q == ZERO) ? ONE : ZERO;
      default: res = '0;
    endcase
  end

  assign rshift = {dr_q, dq_q[DATA_WIDTH-1]};
  assign dtrial = rshift - {1'b0, dd_q};
  assign dres   = (op_q == osa_pkg::OP_DIV)
                ? ((dsa_q != dsb_q) ? ZERO - dq_q : dq_q)
                : (dsa_q ? ZERO - dr_q : dr_q);

  always_comb begin
    state_d = state_q;
    sp_d    = sp_q;
    top_d   = top_q;
    b_d     = b_q;
    op_d    = op_q;
    st_d    = st_q;
    ov_d    = ov_q && out_stall_i;
    dq_d    = dq_q;
    dr_d    = dr_q;
    dd_d    = dd_q;
    dcnt_d  = dcnt_q;
    dsa_d   = dsa_q;
    dsb_d   = dsb_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_addr = '0;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          op_d = op_code_i;
          st_d = osa_pkg::ST_OK;
          case (kind_i)
            osa_pkg::KIND_PUSH: begin
              if (sp_q >= CW'(STACK_DEPTH)) begin
                st_d = osa_pkg::ST_OVER;
              end else begin
                wr_en   = 1'b1;
                wr_addr = sp_q[AW-1:0];
                wr_data = DATA_WIDTH'(push_value_i);
                top_d   = DATA_WIDTH'(push_value_i);
                sp_d    = sp_q + 1'b1;
              end
              state_d = S_DONE;
            end
            osa_pkg::KIND_OP: begin
              if (op_code_i <= osa_pkg::OP_EQ) begin
                if (sp_q < CW'(2)) begin
                  st_d    = osa_pkg::ST_UNDER;
                  state_d = S_DONE;
                end else begin
                  b_d     = top_q;
                  state_d = S_RD_A;
                end
              end else if (op_code_i <= osa_pkg::OP_LOGNOT) begin
                if (sp_q == '0) begin
                  st_d    = osa_pkg::ST_UNDER;
                  state_d = S_DONE;
                end else begin
                  b_d     = top_q;
                  state_d = S_EXEC;
                end
              end else begin
                state_d = S_DONE;
              end
            end
            osa_pkg::KIND_CLEAR: begin
              sp_d    = '0;
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_RD_A: begin
        rd_addr = AW'(sp_q - CW'(2));
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (op_q > osa_pkg::OP_EQ) begin
          wr_en   = 1'b1;
          wr_addr = AW'(sp_q - 1'b1);
          wr_data = res;
          top_d   = res;
          state_d = S_DONE;
        end else if ((op_q == osa_pkg::OP_DIV) || (op_q == osa_pkg::OP_MOD)) begin
          if (b_q == ZERO) begin
            st_d    = osa_pkg::ST_DIVZERO;
            state_d = S_DONE;
          end else begin
            dsa_d   = a_v[DATA_WIDTH-1];
            dsb_d   = b_q[DATA_WIDTH-1];
            dq_d    = a_v[DATA_WIDTH-1] ? ZERO - a_v : a_v;
            dd_d    = b_q[DATA_WIDTH-1] ? ZERO - b_q : b_q;
            dr_d    = '0;
            dcnt_d  = DCW'(DATA_WIDTH);
            state_d = S_DIV;
          end
        end else if (ex_st != osa_pkg::ST_OK) begin
          st_d    = ex_st;
          state_d = S_DONE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(sp_q - CW'(2));
          wr_data = res;
          top_d   = res;
          sp_d    = sp_q - 1'b1;
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (dtrial[DATA_WIDTH]) begin
          dr_d = rshift[DATA_WIDTH-1:0];
          dq_d = {dq_q[DATA_WIDTH-2:0], 1'b0};
        end else begin
          dr_d = dtrial[DATA_WIDTH-1:0];
          dq_d = {dq_q[DATA_WIDTH-2:0], 1'b1};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCW'(1)) begin
          state_d = S_DIVWB;
        end
      end
      S_DIVWB: begin
        wr_en   = 1'b1;
        wr_addr = AW'(sp_q - CW'(2));
        wr_data = dres;
        top_d   = dres;
        sp_d    = sp_q - 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        ov_d    = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    b_q    <= b_d;
    op_q   <= op_d;
    st_q   <= st_d;
    dq_q   <= dq_d;
    dr_q   <= dr_d;
    dd_q   <= dd_d;
    dcnt_q <= dcnt_d;
    dsa_q  <= dsa_d;
    dsb_q  <= dsb_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = st_q;
  assign top_value_o   = (sp_q == '0) ? 32'sd0 : 32'(top_q);
  assign stack_count_o = 5'(sp_q);

`include "operand_stack_alu_assert.svh"

  `OSA_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, sp_q <= CW'(STACK_DEPTH), "stack count above depth")
  `OSA_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, state_q != S_IDLE, !take, "accepted while busy")
  `OSA_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, state_q == S_DONE, out_valid_o, "result not presented")
  `OSA_ASSERT_NEXT(a_hold_result, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o), "stalled result changed")

endmodule

[verif/tb_operand_stack_alu.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for operand_stack_alu
// Drives push, operate, clear and ignored transactions with random gaps and output
// stalls, predicts every result with a behavioral stack model and compares
// status, top value and entry count in order.
// ---------------------------------------------------------------------------
module tb_operand_stack_alu;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] top_value;
    logic [4:0]  stack_count;
  } alu_result_t;

  class stack_scoreboard;
    logic [31:0] entries [DEPTH];
    int unsigned depth_used;
    alu_result_t pending_results [$];
    int unsigned error_count;

    function new();
      depth_used = 0;
      error_count = 0;
    endfunction

    function logic [2:0] apply_binary(logic [4:0] op, logic signed [31:0] a,
                                      logic signed [31:0] b, output logic [31:0] r);
      logic [31:0] ma, mb;
      r = '0;
      case (op)
        osa_pkg::OP_ADD: r = a + b;
        osa_pkg::OP_SUB: r = a - b;
        osa_pkg::OP_MUL: r = a * b;
        osa_pkg::OP_DIV, osa_pkg::OP_MOD: begin
          if (b == 0) return osa_pkg::ST_DIVZERO;
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          if (op == osa_pkg::OP_DIV) begin
            r = ma / mb;
            if (a[31] != b[31]) r = -r;
          end else begin
            r = ma % mb;
            if (a[31]) r = -r;
          end
        end
        osa_pkg::OP_LOR: r = (a != 0 || b != 0);
        osa_pkg::OP_XOR: r = a ^ b;
        osa_pkg::OP_LAND: r = (a != 0 && b != 0);
        osa_pkg::OP_AND: r = a & b;
        osa_pkg::OP_OR: r = a | b;
        osa_pkg::OP_SHL, osa_pkg::OP_SHR: begin
          if (b < 0 || b > 31) return osa_pkg::ST_SHIFT;
          r = (op == osa_pkg::OP_SHL) ? (a << b[4:0]) : (a >>> b[4:0]);
        end
        osa_pkg::OP_LT: r = (a < b);
        osa_pkg::OP_GT: r = (a > b);
        default: r = (a == b);
      endcase
      return osa_pkg::ST_OK;
    endfunction

    // Notes an accepted input and queues the expected result.
    function void note_input(logic [1:0] kind, logic [31:0] value, logic [4:0] op);
      logic [2:0] st;
      logic [31:0] r;
      alu_result_t res;
      st = osa_pkg::ST_OK;
      case (kind)
        osa_pkg::KIND_PUSH: begin
          if (depth_used >= DEPTH) st = osa_pkg::ST_OVER;
          else begin
            entries[depth_used] = value;
            depth_used++;
          end
        end
        osa_pkg::KIND_OP: begin
          if (op <= osa_pkg::OP_EQ) begin
            if (depth_used < 2) st = osa_pkg::ST_UNDER;
            else begin
              st = apply_binary(op, entries[depth_used-2], entries[depth_used-1], r);
              if (st == osa_pkg::ST_OK) begin
                depth_used--;
                entries[depth_used-1] = r;
              end
            end
          end else if (op <= osa_pkg::OP_LOGNOT) begin
            if (depth_used < 1) st = osa_pkg::ST_UNDER;
            else begin
              r = entries[depth_used-1];
              if (op == osa_pkg::OP_NEG) r = -r;
              else if (op == osa_pkg::OP_BITNOT) r = ~r;
              else if (op == osa_pkg::OP_LOGNOT) r = (r == 0);
              entries[depth_used-1] = r;
            end
          end
        end
        osa_pkg::KIND_CLEAR: depth_used = 0;
        default: ;
      endcase
      res.status = st;
      res.top_value = depth_used ? entries[depth_used-1] : '0;
      res.stack_count = depth_used[4:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] top, logic [4:0] cnt);
      alu_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting");
        error_count++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (st !== exp_res.status) begin
        $error("status expected %0d actual %0d", exp_res.status, st);
        error_count++;
      end
      if (top !== exp_res.top_value) begin
        $error("top_value expected %h actual %h", exp_res.top_value, top);
        error_count++;
      end
      if (cnt !== exp_res.stack_count) begin
        $error("stack_count expected %0d actual %0d", exp_res.stack_count, cnt);
        error_count++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] kind_i;
  logic signed [31:0] push_value_i;
  logic [4:0] op_code_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [2:0] status_o;
  logic signed [31:0] top_value_o;
  logic [4:0] stack_count_o;

  stack_scoreboard calc_board;
  int unsigned model_depth;
  int unsigned burst_left;
  bit stall_enable;

  operand_stack_alu dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Receiver stalls in bursts; quiet stretches come when stall_enable is low.
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else if (!stall_enable) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0) ? ~out_stall_i : out_stall_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      calc_board.check_result(status_o, top_value_o, stack_count_o);
  end

  // Sends one transaction, with a random gap between bursts.
  task automatic send_item(logic [1:0] kind, logic [31:0] value, logic [4:0] op);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i <= kind;
    push_value_i <= value;
    op_code_i <= op;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    calc_board.note_input(kind, value, op);
    if (kind == osa_pkg::KIND_PUSH && model_depth < DEPTH) model_depth++;
    else if (kind == osa_pkg::KIND_CLEAR) model_depth = 0;
    else model_depth = calc_board.depth_used;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (calc_board.pending_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [4:0] op;
    int n;
    calc_board = new();
    model_depth = 0;
    burst_left = 0;
    stall_enable = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = osa_pkg::KIND_PUSH;
    push_value_i = '0;
    op_code_i = osa_pkg::OP_ADD;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: underflow on empty stack, min / -1, zero divisor, bad shifts, unknown op, overflow.
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_NEG);
    send_item(osa_pkg::KIND_PUSH, 32'h8000_0000, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_PUSH, 32'hffff_ffff, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_DIV);
    send_item(osa_pkg::KIND_PUSH, 32'hffff_ffff, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_MOD);
    send_item(osa_pkg::KIND_PUSH, 32'd0, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_DIV);
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_MOD);
    send_item(osa_pkg::KIND_PUSH, 32'd32, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_SHL);
    send_item(osa_pkg::KIND_PUSH, 32'hffff_ffff, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_OP, '0, osa_pkg::OP_SHR);
    send_item(osa_pkg::KIND_OP, '0, 5'd31);
    send_item(osa_pkg::KIND_NONE, 32'h7fff_ffff, osa_pkg::OP_ADD);
    for (int i = 0; i < DEPTH + 1; i++)
      send_item(osa_pkg::KIND_PUSH, 32'h7fff_ffff - i, osa_pkg::OP_ADD);
    send_item(osa_pkg::KIND_CLEAR, '0, osa_pkg::OP_ADD);
    drain_results();

    // Random: mostly well-formed operations on a loaded stack.
    for (int i = 0; i < 700; i++) begin
      if (i == 350) begin
        drain_results();
        stall_enable = 1'b0;
      end
      if (i == 500) stall_enable = 1'b1;
      n = $urandom_range(0, 99);
      if (n < 3) send_item(osa_pkg::KIND_CLEAR, $urandom, 5'($urandom));
      else if (n < 5) send_item(osa_pkg::KIND_NONE, $urandom, 5'($urandom));
      else if (n < 45 || model_depth < 2 && n < 85)
        send_item(osa_pkg::KIND_PUSH, pick_value(), 5'($urandom));
      else begin
        op = (n < 97) ? 5'($urandom_range(0, 18)) : 5'($urandom_range(19, 31));
        send_item(osa_pkg::KIND_OP, $urandom, op);
      end
    end

    drain_results();
    repeat (60) @(negedge clk_i);
    if (calc_board.error_count == 0 && calc_board.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
